// ===== rtl/fqd_pkg.sv =====
// shared types and constants of the fifo queue with delete
`default_nettype none

package fqd_pkg;

	localparam int DATA_W = 32;
	localparam int LEN_W  = 5;
	localparam int OP_W   = 2;

	localparam logic [OP_W-1:0] OP_ENQ = 2'd0;
	localparam logic [OP_W-1:0] OP_DEQ = 2'd1;
	localparam logic [OP_W-1:0] OP_DEL = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]   opcode;
		logic [DATA_W-1:0] item_data;
	} in_t;

	typedef struct packed {
		logic              status;
		logic [DATA_W-1:0] data_out;
		logic [LEN_W-1:0]  length;
	} out_t;

	typedef struct packed {
		logic load;
		logic enq_wr;
		logic rd_head;
		logic scan;
		logic finish;
		logic ok;
	} cmd_t;

	typedef struct packed {
		logic op_enq;
		logic op_deq;
		logic op_del;
		logic zero;
		logic full;
		logic empty;
		logic scan_end;
		logic found;
	} sts_t;

endpackage

`default_nettype wire

// ===== rtl/fqd_ctrl.sv =====
// controller state machine of the fifo queue with delete
`default_nettype none

module fqd_ctrl
	import fqd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EXEC = 4'b0010,
		S_DEQ  = 4'b0100,
		S_DEL  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_nx = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.op_enq && !sts.zero && !sts.full) begin
					cmd.enq_wr = 1'b1;
					cmd.finish = 1'b1;
					cmd.ok     = 1'b1;
					state_nx   = S_IDLE;
				end else if (sts.op_deq && !sts.empty) begin
					cmd.rd_head = 1'b1;
					state_nx    = S_DEQ;
				end else if (sts.op_del && !sts.zero && !sts.empty) begin
					cmd.rd_head = 1'b1;
					state_nx    = S_DEL;
				end else begin
					cmd.finish = 1'b1;
					state_nx   = S_IDLE;
				end
			end
			S_DEQ: begin
				cmd.finish = 1'b1;
				cmd.ok     = 1'b1;
				state_nx   = S_IDLE;
			end
			S_DEL: begin
				cmd.scan = 1'b1;
				if (sts.scan_end) begin
					cmd.finish = 1'b1;
					cmd.ok     = sts.found;
					state_nx   = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/fqd_datapath.sv =====
// entry store, pointers and result register of the fifo queue with delete
`default_nettype none

module fqd_datapath
	import fqd_pkg::*;
#(
	parameter int DEPTH        = 16,
	parameter int HANDLE_WIDTH = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire in_t  req,
	input  wire cmd_t cmd,
	output sts_t      sts,
	output out_t      rsp,
	output logic      done
);

	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int SUMW = AW + 1;
	localparam int SW   = (HANDLE_WIDTH < DATA_W) ? HANDLE_WIDTH : DATA_W;

	localparam logic [CW-1:0]   DEPTH_C   = CW'(DEPTH);
	localparam logic [SUMW-1:0] DEPTH_S   = SUMW'(DEPTH);
	localparam logic [AW-1:0]   LAST_SLOT = AW'(DEPTH - 1);

	logic [OP_W-1:0] op_q;
	logic [SW-1:0]   hdl_q;
	logic [AW-1:0]   head_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   off_q;
	logic            found_q;
	logic [SW-1:0]   rdata_q;
	out_t            rsp_q;
	logic            done_q;

	logic [SW-1:0] mem [DEPTH];

	logic [CW-1:0]   rd_off;
	logic [CW-1:0]   wr_off;
	logic [SUMW-1:0] rd_sum;
	logic [SUMW-1:0] wr_sum;
	logic [AW-1:0]   rd_slot;
	logic [AW-1:0]   wr_slot;
	logic            wr_en;
	logic [SW-1:0]   wr_data;
	logic            match;
	logic [CW-1:0]   count_nx;
	logic [CW+LEN_W-1:0]  len_ext;
	logic [SW+DATA_W-1:0] dout_ext;

	// circular addressing
	assign rd_off  = cmd.rd_head ? '0 : off_q + 1'b1;
	assign wr_off  = cmd.enq_wr ? count_q : off_q - 1'b1;
	assign rd_sum  = {1'b0, head_q} + SUMW'(rd_off);
	assign wr_sum  = {1'b0, head_q} + SUMW'(wr_off);
	assign rd_slot = (rd_sum >= DEPTH_S) ? AW'(rd_sum - DEPTH_S) : AW'(rd_sum);
	assign wr_slot = (wr_sum >= DEPTH_S) ? AW'(wr_sum - DEPTH_S) : AW'(wr_sum);

	// shift the tail down by one behind the deleted entry
	assign wr_en   = cmd.enq_wr || (cmd.scan && found_q);
	assign wr_data = cmd.enq_wr ? hdl_q : rdata_q;
	assign match   = !found_q && (rdata_q == hdl_q);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_slot] <= wr_data;
		end
		rdata_q <= mem[rd_slot];
	end

	always_comb begin
		count_nx = count_q;
		if (cmd.ok) begin
			if (op_q == OP_ENQ) begin
				count_nx = count_q + 1'b1;
			end else if (op_q inside {OP_DEQ, OP_DEL}) begin
				count_nx = count_q - 1'b1;
			end
		end
	end

	assign len_ext  = {{LEN_W{1'b0}}, count_nx};
	assign dout_ext = {{DATA_W{1'b0}}, rdata_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= req.opcode;
			hdl_q <= req.item_data[SW-1:0];
		end
		if (cmd.finish) begin
			rsp_q.status   <= !cmd.ok;
			rsp_q.data_out <= (cmd.ok && op_q == OP_DEQ) ? dout_ext[DATA_W-1:0] : '0;
			rsp_q.length   <= len_ext[LEN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			off_q   <= '0;
			found_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.rd_head) begin
				off_q   <= '0;
				found_q <= 1'b0;
			end else if (cmd.scan) begin
				off_q   <= off_q + 1'b1;
				found_q <= found_q || match;
			end
			if (cmd.finish) begin
				count_q <= count_nx;
				if (cmd.ok && op_q == OP_DEQ) begin
					head_q <= (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;
				end
			end
		end
	end

	assign sts.op_enq   = (op_q == OP_ENQ);
	assign sts.op_deq   = (op_q == OP_DEQ);
	assign sts.op_del   = (op_q == OP_DEL);
	assign sts.zero     = (hdl_q == '0);
	assign sts.full     = (count_q == DEPTH_C);
	assign sts.empty    = (count_q == '0);
	assign sts.scan_end = (off_q == count_q - 1'b1);
	assign sts.found    = found_q || match;

	assign rsp  = rsp_q;
	assign done = done_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("entry count above depth");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held two cycles");

	a_enq_grows: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && !rsp_q.status && op_q == OP_ENQ |-> count_q == $past(count_q) + 1'b1)
		else $error("enqueue did not add one entry");

	a_err_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && rsp_q.status |-> $stable(count_q) && $stable(head_q))
		else $error("failed beat changed the queue");

	a_deq_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && !rsp_q.status && op_q == OP_DEQ |-> rsp_q.data_out != '0)
		else $error("dequeue returned a zero handle");
`endif

endmodule

`default_nettype wire

// ===== rtl/fifo_queue_with_delete.sv =====
// top level of the fifo queue with delete by value
`default_nettype none

// A beat is taken when start is high and busy is low; its result appears on
// rsp for exactly one cycle with done high, and cannot be held off. An enqueue
// and any beat refused before a search go from exec back to idle, a dequeue
// passes through exec and a dequeue state, and a delete with a nonzero handle
// into a nonempty queue walks all entries held in the delete state, whether
// it finds a match or not, since the search and the compaction walk them
// through the single read and write port of the entry store, one entry per
// cycle. A new beat may start in the cycle done is high.
module fifo_queue_with_delete
	import fqd_pkg::*;
#(
	parameter int DEPTH        = 16,
	parameter int HANDLE_WIDTH = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire in_t  req,
	output out_t      rsp,
	output logic      done
);

	cmd_t cmd;
	sts_t sts;

	fqd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	fqd_datapath #(
		.DEPTH        (DEPTH),
		.HANDLE_WIDTH (HANDLE_WIDTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp),
		.done   (done)
	);

endmodule

`default_nettype wire
